// ===== hw/rtl/ppm_frame_decoder_assert.svh =====
// Assertion macros shared by the PPM frame decoder checker.
`ifndef PPM_FRAME_DECODER_ASSERT_SVH
`define PPM_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, held off while reset is high.
`define PPM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppm_frame_decoder: assertion failed");

// Next-cycle implication, held off while reset is high.
`define PPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppm_frame_decoder: assertion failed");

`endif

// ===== hw/rtl/ppm_pkg.sv =====
// Package: constants, register indexes and controller/datapath link types.
`timescale 1ns / 1ps
package ppm_pkg;

   localparam int CHANNELS  = 8;
   localparam int NSLOTS    = CHANNELS + 1;
   localparam int SLOT_W    = $clog2(NSLOTS);
   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int GAP_W     = 16;
   localparam int STAMP_W   = 32;
   localparam int RES_W     = 17;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 17;
   localparam int LIM_W     = 17;
   localparam int PROD_W    = 2 * GAP_W;
   localparam int DIV_CNT_W = $clog2(PROD_W);

   // floor(v/100) == (v * RECIP_100) >> RECIP_SHIFT for any 16-bit v
   localparam logic [16:0] RECIP_100   = 17'd83887;
   localparam int          RECIP_SHIFT = 23;
   localparam int          RECIP_PROD_W = 33;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESOLUTION = 2'd2;

   localparam logic [GAP_W-1:0] SYNC_RESET = 16'd6000;
   localparam logic [GAP_W-1:0] FULL_RESET = 16'd4000;
   localparam logic [RES_W-1:0] RES_RESET  = 17'd1024;

   typedef struct packed {
      logic            edge_wr;
      logic            lim_mul;
      logic            lim_add;
      logic            load;
      logic            mul;
      logic            div_step;
      logic            fin;
      logic [CH_W-1:0] ch;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

// ===== hw/rtl/ppm_ctrl.sv =====
// Controller: sequences edge updates and the per-channel refresh walk.
`timescale 1ns / 1ps
module ppm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   input  logic                req_edge_rising,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ppm_pkg::cmd_type    cmd,
   input  ppm_pkg::status_type status
);
   import ppm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LIM_MUL,
      S_LIM_ADD,
      S_LOAD,
      S_MUL,
      S_DIV,
      S_FIN,
      S_OUT
   } state_type;

   state_type       state_ff, state_in;
   logic [CH_W-1:0] ch_ff, ch_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            ch_last;

   assign ch_last = (ch_ff == CH_W'(CHANNELS - 1));

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_kind) begin
               state_in = S_LIM_MUL;
               ch_in    = '0;
            end
         end
         S_LIM_MUL: state_in = S_LIM_ADD;
         S_LIM_ADD: state_in = S_LOAD;
         S_LOAD:    state_in = S_MUL;
         S_MUL:     state_in = S_DIV;
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            state_in     = S_OUT;
            rsp_valid_in = 1'b1;
         end
         S_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (ch_last) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_LOAD;
                  ch_in    = ch_ff + CH_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.ch       = ch_ff;
      cmd.edge_wr  = (state_ff == S_IDLE) && req_valid && !req_kind && req_edge_rising;
      cmd.lim_mul  = (state_ff == S_LIM_MUL);
      cmd.lim_add  = (state_ff == S_LIM_ADD);
      cmd.load     = (state_ff == S_LOAD);
      cmd.mul      = (state_ff == S_MUL);
      cmd.div_step = (state_ff == S_DIV);
      cmd.fin      = (state_ff == S_FIN);
   end

endmodule

// ===== hw/rtl/ppm_datapath.sv =====
// Datapath: CSRs, gap store, limit calc, multiplier and serial divider.
`timescale 1ns / 1ps
module ppm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [ppm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ppm_pkg::CSR_DAT_W-1:0]     csr_data,
   input  logic [ppm_pkg::STAMP_W-1:0]       req_stamp,
   input  ppm_pkg::cmd_type                  cmd,
   output ppm_pkg::status_type               status,
   output logic [ppm_pkg::GAP_W-1:0]         level,
   output logic                              in_range
);
   import ppm_pkg::*;

   logic [GAP_W-1:0]        sync_ff, sync_in;
   logic [GAP_W-1:0]        full_ff, full_in;
   logic [RES_W-1:0]        res_ff, res_in;
   logic [STAMP_W-1:0]      prev_ff, prev_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [GAP_W-1:0]        raw_ff [NSLOTS];
   logic [RECIP_PROD_W-1:0] limprod_ff;
   logic [LIM_W-1:0]        limit_ff;
   logic                    ok_ff;
   logic [GAP_W-1:0]        x_ff;
   logic [GAP_W-2:0]        rem_ff;
   logic [PROD_W-1:0]       quo_ff;
   logic [DIV_CNT_W-1:0]    cnt_ff;
   logic [GAP_W-1:0]        level_ff;
   logic                    in_range_ff;

   logic [STAMP_W-1:0]      diff;
   logic [GAP_W-1:0]        gap;
   logic [GAP_W-2:0]        half;
   logic [RES_W-1:0]        res_m1;
   logic [GAP_W-1:0]        top;
   logic [GAP_W-1:0]        g;
   logic [9:0]              hundredths;
   logic [GAP_W-1:0]        trial;
   logic [GAP_W-1:0]        trial_sub;
   logic                    fits;
   logic [GAP_W-1:0]        level_in;

   assign half   = full_ff[GAP_W-1:1];
   assign res_m1 = res_ff - RES_W'(1);
   // Top level is res-1, saturated to 16 bits, zero when res is zero
   assign top    = (res_ff == '0) ? '0 :
                   (res_m1[RES_W-1] ? {GAP_W{1'b1}} : res_m1[GAP_W-1:0]);

   assign diff = req_stamp - prev_ff;
   assign gap  = diff[GAP_W-1:0];
   assign g    = raw_ff[SLOT_W'(cmd.ch)];

   assign hundredths = limprod_ff[RECIP_PROD_W-1:RECIP_SHIFT];

   assign trial     = {rem_ff, quo_ff[PROD_W-1]};
   assign trial_sub = trial - {1'b0, half};
   assign fits      = (trial >= {1'b0, half});

   always_comb begin
      sync_in = sync_ff;
      full_in = full_ff;
      res_in  = res_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SYNC_TICKS: sync_in = csr_data[GAP_W-1:0];
            CSR_FULL_SCALE: full_in = csr_data[GAP_W-1:0];
            CSR_RESOLUTION: res_in  = csr_data[RES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prev_in = prev_ff;
      slot_in = slot_ff;
      if (cmd.edge_wr) begin
         prev_in = req_stamp;
         if (gap > sync_ff || slot_ff == SLOT_W'(NSLOTS - 1)) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end
   end

   always_comb begin
      if (!ok_ff) begin
         level_in = '0;
      end else if (half == '0) begin
         level_in = top;
      end else if (quo_ff[PROD_W-1:GAP_W] != '0 || quo_ff[GAP_W-1:0] > top) begin
         level_in = top;
      end else begin
         level_in = quo_ff[GAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= SYNC_RESET;
         full_ff <= FULL_RESET;
         res_ff  <= RES_RESET;
         prev_ff <= '0;
         slot_ff <= '0;
         for (int i = 0; i < NSLOTS; i++) begin
            raw_ff[i] <= '0;
         end
      end else begin
         sync_ff <= sync_in;
         full_ff <= full_in;
         res_ff  <= res_in;
         prev_ff <= prev_in;
         slot_ff <= slot_in;
         if (cmd.edge_wr) begin
            raw_ff[slot_ff] <= gap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.mul) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + DIV_CNT_W'(1);
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.lim_mul) begin
         limprod_ff <= RECIP_PROD_W'(full_ff) * RECIP_PROD_W'(RECIP_100);
      end
      if (cmd.lim_add) begin
         limit_ff <= LIM_W'(full_ff) + LIM_W'({hundredths, 3'b000}) +
                     LIM_W'({hundredths, 1'b0});
      end
      if (cmd.load) begin
         ok_ff <= ({1'b0, g} <= limit_ff);
         x_ff  <= (g < {1'b0, half}) ? '0 : g - {1'b0, half};
      end
      if (cmd.mul) begin
         quo_ff <= PROD_W'(x_ff) * PROD_W'(top);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[PROD_W-2:0], fits};
         rem_ff <= fits ? trial_sub[GAP_W-2:0] : trial[GAP_W-2:0];
      end
      if (cmd.fin) begin
         level_ff    <= level_in;
         in_range_ff <= ok_ff;
      end
   end

   assign status.div_done = cmd.div_step && (cnt_ff == DIV_CNT_W'(PROD_W - 1));
   assign level    = level_ff;
   assign in_range = in_range_ff;

endmodule

// ===== hw/rtl/ppm_frame_decoder.sv =====
// PPM frame decoder top level: ports, controller and datapath.
// Edge item: accepted while idle; the next item may follow right after.
// Refresh item: the range limit first (multiply, then add), then per channel
//   load, multiply, 32-step bit-serial divide, finish and present; the present
//   step holds until rsp_ready is high.
// One item at a time: req_ready is low while a refresh is in progress.
// Synchronous active-high reset restores register defaults and zeroes the gap store.
`timescale 1ns / 1ps
module ppm_frame_decoder (
   input  logic                          clock,
   input  logic                          reset,
   // configuration writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ppm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ppm_pkg::CSR_DAT_W-1:0] csr_data,
   // request items
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic                          req_edge_rising,
   input  logic [ppm_pkg::STAMP_W-1:0]   req_stamp,
   // response items
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [4:0]                    rsp_channel,
   output logic [ppm_pkg::GAP_W-1:0]     rsp_level,
   output logic                          rsp_in_range,
   output logic                          rsp_last
);
   import ppm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Register writes are always taken; they land in the datapath directly.
   assign csr_ready = 1'b1;

   // Controller: owns the channel counter and the response valid flag.
   ppm_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_kind        (req_kind),
      .req_edge_rising (req_edge_rising),
      .req_ready       (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .cmd             (cmd),
      .status          (status)
   );

   // Datapath: gap capture on rising edges, scaling on refresh.
   ppm_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_stamp (req_stamp),
      .cmd       (cmd),
      .status    (status),
      .level     (rsp_level),
      .in_range  (rsp_in_range)
   );

   // Channel numbers count from one; flag the final channel of the refresh.
   assign rsp_channel = 5'(cmd.ch) + 5'd1;
   assign rsp_last    = (cmd.ch == CH_W'(CHANNELS - 1));

endmodule

// ===== hw/rtl/ppm_checker.sv =====
// Port-level checker for the PPM frame decoder, bound to the top level.
`timescale 1ns / 1ps
`include "ppm_frame_decoder_assert.svh"
module ppm_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [4:0]                rsp_channel,
   input logic [ppm_pkg::GAP_W-1:0] rsp_level,
   input logic                      rsp_in_range,
   input logic                      rsp_last
);
   import ppm_pkg::*;

   `PPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_level))
   `PPM_ASSERT_NOW(a_no_req_during_rsp, clock, reset, rsp_valid, !req_ready)
   `PPM_ASSERT_NOW(a_chan_span, clock, reset, rsp_valid, rsp_channel >= 5'd1 && rsp_channel <= 5'(CHANNELS))
   `PPM_ASSERT_NOW(a_last_chan, clock, reset, rsp_valid && rsp_last, rsp_channel == 5'(CHANNELS))
   `PPM_ASSERT_NOW(a_oor_zero, clock, reset, rsp_valid && !rsp_in_range, rsp_level == '0)

endmodule

bind ppm_frame_decoder ppm_checker u_ppm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_channel  (rsp_channel),
   .rsp_level    (rsp_level),
   .rsp_in_range (rsp_in_range),
   .rsp_last     (rsp_last)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the PPM frame decoder: directed table, then random frames.
`timescale 1ns / 1ps
module tb;
   import ppm_pkg::*;

   // Index 3 has no register behind it; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int ITEMS_PER_PHASE = 55;
   localparam int NUM_PHASES      = 8;
   localparam int DIRECTED_ROWS   = 23;

   // One channel result as it leaves the block.
   typedef struct packed {
      logic [4:0]       channel;
      logic [GAP_W-1:0] level;
      logic             in_range;
      logic             last;
   } chan_result_type;

   // One row of the directed table. When typed is set, every channel of a
   // refresh must show want_level / want_ok (read off the frame by hand).
   typedef struct packed {
      logic               kind;
      logic               rising;
      logic [STAMP_W-1:0] stamp;
      logic               typed;
      logic [GAP_W-1:0]   want_level;
      logic               want_ok;
   } stim_row_type;

   typedef struct packed {
      logic [GAP_W-1:0] sync;
      logic [GAP_W-1:0] full;
      logic [RES_W-1:0] res;
   } decoder_cfg_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_kind = 1'b0;
   logic                 req_edge_rising = 1'b0;
   logic [STAMP_W-1:0]   req_stamp = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [4:0]           rsp_channel;
   logic [GAP_W-1:0]     rsp_level;
   logic                 rsp_in_range;
   logic                 rsp_last;

   // Decoder image kept by the testbench: registers, edge history, gap store.
   logic [GAP_W-1:0]     sync_len;
   logic [GAP_W-1:0]     full_len;
   logic [RES_W-1:0]     res_levels;
   logic [STAMP_W-1:0]   last_rise;
   logic [4:0]           slot_ptr;
   logic [GAP_W-1:0]     gap_store [NSLOTS];

   chan_result_type      levels_due [$];
   int unsigned          fault_count = 0;
   int unsigned          cycle_count = 0;
   int unsigned          send_idle_pct = 0;
   int unsigned          recv_stall_pct = 0;

   // Directed frame. Reset config: sync 6000, full scale 4000, 1024 levels,
   // so the in-range limit is 4400 and half scale is 2000.
   stim_row_type directed [DIRECTED_ROWS] = '{
      // refresh straight out of reset: empty store reads as level 0, in range
      '{1'b1, 1'b0, 32'd0,          1'b1, 16'd0,    1'b1},
      // falling edge is dropped
      '{1'b0, 1'b0, 32'hFFFF_FFFF,  1'b0, 16'd0,    1'b0},
      // refresh ignores its edge and stamp fields
      '{1'b1, 1'b1, 32'hFFFF_FFFF,  1'b1, 16'd0,    1'b1},
      // eight full-scale gaps fill channels 1..8
      '{1'b0, 1'b1, 32'd4000,       1'b0, 16'd0,    1'b0},
      '{1'b0, 1'b1, 32'd8000,       1'b0, 16'd0,    1'b0},
      '{1'b0, 1'b1, 32'd12000,      1'b0, 16'd0,    1'b0},
      '{1'b0, 1'b1, 32'd16000,      1'b0, 16'd0,    1'b0},
      '{1'b0, 1'b1, 32'd20000,      1'b0, 16'd0,    1'b0},
      '{1'b0, 1'b1, 32'd24000,      1'b0, 16'd0,    1'b0},
      '{1'b0, 1'b1, 32'd28000,      1'b0, 16'd0,    1'b0},
      '{1'b0, 1'b1, 32'd32000,      1'b0, 16'd0,    1'b0},
      '{1'b0, 1'b0, 32'd33000,      1'b0, 16'd0,    1'b0},
      // full scale maps to the top level on every channel
      '{1'b1, 1'b0, 32'd0,          1'b1, 16'd1023, 1'b1},
      // gap one above sync length: frame sync
      '{1'b0, 1'b1, 32'd38001,      1'b0, 16'd0,    1'b0},
      // one tick past the range limit, then exactly on it
      '{1'b0, 1'b1, 32'd42402,      1'b0, 16'd0,    1'b0},
      '{1'b0, 1'b1, 32'd46802,      1'b0, 16'd0,    1'b0},
      // below half scale clamps to level 0
      '{1'b0, 1'b1, 32'd48801,      1'b0, 16'd0,    1'b0},
      // gap equal to sync length is still a channel
      '{1'b0, 1'b1, 32'd54801,      1'b0, 16'd0,    1'b0},
      // timestamp counter wraps between these edges
      '{1'b0, 1'b1, 32'hFFFF_F000,  1'b0, 16'd0,    1'b0},
      '{1'b0, 1'b1, 32'h0000_0388,  1'b0, 16'd0,    1'b0},
      // largest and smallest gap
      '{1'b0, 1'b1, 32'h0001_0387,  1'b0, 16'd0,    1'b0},
      '{1'b0, 1'b1, 32'h0001_0387,  1'b0, 16'd0,    1'b0},
      '{1'b1, 1'b0, 32'd0,          1'b0, 16'd0,    1'b0}
   };

   ppm_frame_decoder uut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_edge_rising (req_edge_rising),
      .req_stamp       (req_stamp),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_channel     (rsp_channel),
      .rsp_level       (rsp_level),
      .rsp_in_range    (rsp_in_range),
      .rsp_last        (rsp_last)
   );

   always #5 clock = ~clock;

   // Map an in-range gap to an output level: clamp up to half scale, drop
   // the offset, scale by (levels-1)/half and saturate at the top level.
   function automatic logic [GAP_W-1:0] scale_level(input logic [GAP_W-1:0] gap,
                                                    input logic [GAP_W-1:0] full,
                                                    input logic [RES_W-1:0] res);
      logic [RES_W-1:0] top;
      logic [GAP_W-1:0] half;
      logic [GAP_W-1:0] g;
      logic [47:0]      quot;
      top  = (res == '0) ? '0 : res - 1'b1;
      if (top > 17'd65535)
         top = 17'd65535;
      half = full >> 1;
      if (half == '0)
         return top[GAP_W-1:0];
      g = (gap < half) ? half : gap;
      quot = ({32'd0, g - half} * {31'd0, top}) / {32'd0, half};
      if (quot > {31'd0, top})
         quot = {31'd0, top};
      return quot[GAP_W-1:0];
   endfunction

   // Advance the decoder image by one accepted item; a refresh queues the
   // channel results it must produce.
   task automatic decode_item(input logic kind, input logic rising,
                              input logic [STAMP_W-1:0] stamp, input logic typed,
                              input logic [GAP_W-1:0] want_level, input logic want_ok);
      logic [STAMP_W-1:0] span;
      logic [GAP_W-1:0]   gap;
      logic [4:0]         nxt;
      int                 limit;
      chan_result_type    res;
      if (kind == 1'b0) begin
         if (rising) begin
            span = stamp - last_rise;
            gap  = span[GAP_W-1:0];
            gap_store[slot_ptr] = gap;
            nxt = (gap > sync_len) ? 5'd0 : slot_ptr + 5'd1;
            if (nxt >= NSLOTS)
               nxt = 5'd0;
            slot_ptr  = nxt;
            last_rise = stamp;
         end
      end else begin
         limit = int'(full_len) + (int'(full_len) / 100) * 10;
         for (int i = 0; i < CHANNELS; i++) begin
            res.channel  = 5'(i + 1);
            res.in_range = (int'(gap_store[i]) <= limit);
            res.level    = res.in_range ? scale_level(gap_store[i], full_len, res_levels)
                                        : '0;
            res.last     = (i == CHANNELS - 1);
            if (typed) begin
               res.level    = want_level;
               res.in_range = want_ok;
            end
            levels_due.push_back(res);
         end
      end
   endtask

   // Present one request item, idling first at the phase's rate, and hold
   // it until accepted. Valid is left high so a following item can chain.
   task automatic send_item(input logic kind, input logic rising,
                            input logic [STAMP_W-1:0] stamp, input logic typed,
                            input logic [GAP_W-1:0] want_level, input logic want_ok);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_edge_rising <= rising;
      req_stamp       <= stamp;
      do @(posedge clock); while (!req_ready);
      decode_item(kind, rising, stamp, typed, want_level, want_ok);
   endtask

   // Write one register and mirror it. Valid stays high for back-to-back writes.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SYNC_TICKS: sync_len   = val[GAP_W-1:0];
         CSR_FULL_SCALE: full_len   = val[GAP_W-1:0];
         CSR_RESOLUTION: res_levels = val[RES_W-1:0];
         default: ;
      endcase
   endtask

   // Drop valid, wait out every queued result, then keep clocking so the
   // block is surely idle before the next register write.
   task automatic settle();
      req_valid <= 1'b0;
      while (levels_due.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Result checker: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      chan_result_type got;
      chan_result_type want;
      got = '{rsp_channel, rsp_level, rsp_in_range, rsp_last};
      if (!reset && rsp_valid && rsp_ready) begin
         if (levels_due.size() == 0) begin
            $display("%0t: unexpected result ch %0d level %0d in_range %0b last %0b",
                     $time, got.channel, got.level, got.in_range, got.last);
            fault_count++;
         end else begin
            want = levels_due.pop_front();
            if (got !== want) begin
               $display("%0t: expected ch %0d level %0d in_range %0b last %0b",
                        $time, want.channel, want.level, want.in_range, want.last);
               $display("%0t:   actual ch %0d level %0d in_range %0b last %0b",
                        $time, got.channel, got.level, got.in_range, got.last);
               fault_count++;
            end
         end
      end
      // stall the result channel at the phase's rate
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ppm_frame_decoder test failed");
         $finish;
      end
   end

   initial begin : stimulus
      decoder_cfg_type    settings [NUM_PHASES];
      int unsigned        idle_modes [4][2];
      int                 counted;
      int                 frame_pos;
      int                 lo;
      int                 hi;
      int                 limit;
      int                 gap;
      int                 pick;
      logic               kind;
      logic               rising;
      logic [STAMP_W-1:0] stamp;

      // Register settings per phase: defaults, top extremes, bottom extremes,
      // a mid point, a random draw, then half scale of zero with levels past
      // the 16-bit top, zero full scale with zero levels, and a single level.
      settings = '{
         '{16'd6000,  16'd4000,  17'd1024},
         '{16'd65535, 16'd65535, 17'd65536},
         '{16'd0,     16'd2,     17'd2},
         '{16'd3000,  16'd2000,  17'd4096},
         '{16'd0,     16'd0,     17'd0},
         '{16'd20000, 16'd1,     17'd131071},
         '{16'd6000,  16'd0,     17'd0},
         '{16'd9000,  16'd4000,  17'd1}
      };
      // sender idle / receiver stall percentages
      idle_modes = '{'{0, 0}, '{76, 0}, '{0, 76}, '{27, 27}};

      sync_len   = SYNC_RESET;
      full_len   = FULL_RESET;
      res_levels = RES_RESET;
      last_rise  = '0;
      slot_ptr   = '0;
      foreach (gap_store[i])
         gap_store[i] = '0;
      frame_pos  = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table at full rate, reset register values.
      for (int r = 0; r < DIRECTED_ROWS; r++)
         send_item(directed[r].kind, directed[r].rising, directed[r].stamp,
                   directed[r].typed, directed[r].want_level, directed[r].want_ok);
      settle();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == 4)
            settings[ph] = '{16'($urandom_range(0, 65535)), 16'($urandom_range(2, 65535)),
                             17'($urandom_range(2, 65536))};
         send_idle_pct  = idle_modes[ph % 4][0];
         recv_stall_pct = idle_modes[ph % 4][1];

         // Reprogram while idle; bit 16 of a 16-bit register must be dropped.
         write_reg(CSR_SYNC_TICKS, {1'($urandom_range(0, 1)), settings[ph].sync});
         write_reg(CSR_FULL_SCALE, {1'($urandom_range(0, 1)), settings[ph].full});
         write_reg(CSR_RESOLUTION, settings[ph].res);
         if (ph == 0)
            write_reg(CSR_SPARE, '1);
         csr_valid <= 1'b0;

         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            pick  = $urandom_range(0, 99);
            limit = int'(full_len) + (int'(full_len) / 100) * 10;
            if (pick < 8) begin
               // noise: anything at all
               kind   = 1'($urandom_range(0, 1));
               rising = 1'($urandom_range(0, 1));
               stamp  = $urandom();
            end else if (pick < 20) begin
               // refresh with junk in the unused fields
               kind   = 1'b1;
               rising = 1'($urandom_range(0, 1));
               stamp  = $urandom();
            end else if (pick < 35) begin
               // falling edge somewhere inside the current pulse
               kind   = 1'b0;
               rising = 1'b0;
               stamp  = last_rise + $urandom_range(0, 4000);
            end else begin
               // next rising edge of a well-formed frame: sync gap, then channels
               kind   = 1'b0;
               rising = 1'b1;
               if (frame_pos == 0 && sync_len != 16'hFFFF) begin
                  lo  = int'(sync_len) + 1;
                  hi  = (2 * int'(sync_len) + 1 > 65535) ? 65535 : 2 * int'(sync_len) + 1;
                  gap = $urandom_range(hi, lo);
               end else if ($urandom_range(0, 99) < 75) begin
                  // mostly around full scale, straddling the range limit
                  lo  = int'(full_len) / 4;
                  hi  = int'(full_len) + int'(full_len) / 5 + 2;
                  if (hi > 65535)
                     hi = 65535;
                  gap = $urandom_range(hi, lo);
               end else begin
                  case ($urandom_range(0, 4))
                     0: gap = 0;
                     1: gap = 65535;
                     2: gap = (limit > 65535) ? 65535 : limit;
                     3: gap = (limit + 1 > 65535) ? 65535 : limit + 1;
                     default: gap = $urandom_range(0, 65535);
                  endcase
               end
               frame_pos = (frame_pos + 1) % NSLOTS;
               // random upper bits keep the low 16 bits of the gap and make wraps
               stamp = last_rise + 32'(gap) + ($urandom() << 16);
            end
            send_item(kind, rising, stamp, 1'b0, '0, 1'b0);
            // every item counts, falling edges included
            counted++;
         end
         settle();
      end

      if (fault_count == 0)
         $display("ppm_frame_decoder test passed");
      else
         $display("ppm_frame_decoder test failed");
      $finish;
   end

endmodule
